// File: hw/rtl/efd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and codes for the elevator floor dispatcher.
// ----------------------------------------------------------------------------
package efd_pkg;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int FLOOR_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int TAKEN_W   = 6;
    localparam int FIU_W     = 5;
    localparam int CAP_W     = 6;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ARRIVE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PICKUP   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOORS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_CAPACITY  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd8;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_SCAN = 3'b100
    } efd_state_t;

    // Write controls into the floor store
    typedef struct packed {
        logic cnt_we;
        logic busy_set;
        logic busy_clr;
    } efd_wr_ctl_t;

endpackage

// File: hw/rtl/efd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_if
// Valid/ready channels of the dispatcher: request items and result items.
// ----------------------------------------------------------------------------
interface efd_req_if;
    logic                        valid;
    logic                        ready;
    logic [efd_pkg::OP_W-1:0]    op;
    logic [efd_pkg::FLOOR_W-1:0] floor;

    modport source (output valid, output op, output floor, input ready);
    modport sink   (input valid, input op, input floor, output ready);
endinterface

interface efd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [efd_pkg::STATUS_W-1:0] status;
    logic [efd_pkg::FLOOR_W-1:0]  chosen_floor;
    logic [efd_pkg::TAKEN_W-1:0]  people_taken;

    modport source (output valid, output status, output chosen_floor,
                    output people_taken, input ready);
    modport sink   (input valid, input status, input chosen_floor,
                    input people_taken, output ready);
endinterface

// File: hw/rtl/efd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_store
// Per-floor waiting counts in a two-read, one-write memory, with valid bits
// standing in for the cleared reset value, and per-floor busy flags.
// ----------------------------------------------------------------------------
module efd_store #(
    parameter int NUM_FLOORS = 16,
    parameter int CNT_W      = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(NUM_FLOORS)-1:0]  rd_a_idx,
    input  logic [$clog2(NUM_FLOORS)-1:0]  rd_b_idx,
    output logic [CNT_W-1:0]               rd_a_cnt,
    output logic                           rd_a_busy,
    output logic [CNT_W-1:0]               rd_b_cnt,
    output logic                           rd_b_busy,
    input  efd_pkg::efd_wr_ctl_t           wr_ctl,
    input  logic [$clog2(NUM_FLOORS)-1:0]  wr_idx,
    input  logic [CNT_W-1:0]               wr_cnt
);
    import efd_pkg::*;

    localparam int FW = $clog2(NUM_FLOORS);
    localparam logic [FW:0] NF_L = (FW+1)'(NUM_FLOORS);

    logic [CNT_W-1:0]      mem [NUM_FLOORS];
    logic [NUM_FLOORS-1:0] valid_reg;
    logic [NUM_FLOORS-1:0] busy_reg;
    logic [CNT_W-1:0]      data_a_reg;
    logic [CNT_W-1:0]      data_b_reg;
    logic                  vld_a_reg;
    logic                  vld_b_reg;
    logic                  busy_a_reg;
    logic                  busy_b_reg;
    logic                  a_in_range;
    logic                  b_in_range;

    assign a_in_range = {1'b0, rd_a_idx} < NF_L;
    assign b_in_range = {1'b0, rd_b_idx} < NF_L;

    // Count memory write
    always_ff @(posedge clk)
    begin
        if (wr_ctl.cnt_we)
        begin
            mem[wr_idx] <= wr_cnt;
        end
    end

    // Registered reads on both ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= mem[rd_a_idx];
            data_b_reg <= mem[rd_b_idx];
            vld_a_reg  <= a_in_range ? valid_reg[rd_a_idx] : 1'b0;
            vld_b_reg  <= b_in_range ? valid_reg[rd_b_idx] : 1'b0;
            busy_a_reg <= a_in_range ? busy_reg[rd_a_idx] : 1'b0;
            busy_b_reg <= b_in_range ? busy_reg[rd_b_idx] : 1'b0;
        end
    end

    // Valid bits and busy flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            busy_reg  <= '0;
        end
        else
        begin
            if (wr_ctl.cnt_we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (wr_ctl.busy_set)
            begin
                busy_reg[wr_idx] <= 1'b1;
            end
            else if (wr_ctl.busy_clr)
            begin
                busy_reg[wr_idx] <= 1'b0;
            end
        end
    end

    // Never-written entries read as zero
    assign rd_a_cnt  = vld_a_reg ? data_a_reg : '0;
    assign rd_b_cnt  = vld_b_reg ? data_b_reg : '0;
    assign rd_a_busy = busy_a_reg;
    assign rd_b_busy = busy_b_reg;

endmodule

// File: hw/rtl/elevator_floor_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_floor_dispatcher
// Waiting counts and busy flags per floor; arrivals, dispatch and pickups.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one item (op, floor); result returns exactly one item
//   (status, chosen_floor, people_taken) for each request, in order.
//   Configuration is written through cfg_we/cfg_idx/cfg_data while idle:
//   index 0 is floors_in_use, index 1 is car_capacity.
// Timing:
//   Arrival, pickup and unused ops: decided in S_EVAL, then registered.
//   Dispatch: checks the floor in S_EVAL, then scans to distance D (at most
//   about NUM_FLOORS); the outward scan evaluates one distance per cycle,
//   reading the floor above and below through the two store read ports.
//   request.ready is high only while the sequencer is idle; one item is
//   worked on at a time. The result register lets the next item in while
//   a result still waits.
// Reset:
//   All counts and busy flags read as zero, floors_in_use = 16,
//   car_capacity = 8. No clearing pass is needed.
// Stall:
//   If result.ready is low when a second result is ready, the sequencer
//   holds its final step until the result register frees up.
// ----------------------------------------------------------------------------
module elevator_floor_dispatcher #(
    parameter int NUM_FLOORS  = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    efd_req_if.sink                         request,
    efd_rsp_if.source                       result,
    input  logic                            cfg_we,
    input  logic [efd_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [efd_pkg::CFG_W-1:0]       cfg_data
);
    import efd_pkg::*;

    localparam int FW = $clog2(NUM_FLOORS);
    localparam int CW = $clog2(QUEUE_DEPTH);
    localparam int PW = $clog2(NUM_FLOORS + 16) + 1;
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [PW-1:0] NF_P = PW'(NUM_FLOORS);
    localparam logic [CW:0]   QD_L = (CW+1)'(QUEUE_DEPTH);

    efd_state_t            state_reg, state_next;
    logic [OP_W-1:0]       op_reg;
    logic [PW-1:0]         start_reg, start_next;
    logic [PW-1:0]         d_reg, d_next;
    logic [FIU_W-1:0]      fiu_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [FLOOR_W-1:0]    chosen_reg;
    logic [TAKEN_W-1:0]    taken_reg;

    logic                  accept;
    logic                  out_free;
    logic                  finish;
    logic                  commit;
    logic                  stall;
    logic [PW-1:0]         n_srv;
    logic                  start_srv;
    logic [PW-1:0]         iss_d;
    logic [PW-1:0]         addr_a;
    logic [PW-1:0]         addr_b;
    logic [PW-1:0]         up_pos;
    logic [PW-1:0]         dn_pos;
    logic                  up_srv;
    logic                  dn_srv;
    logic [CW-1:0]         up_free;
    logic [CW-1:0]         dn_free;
    logic [MW-1:0]         cnt_ext;
    logic [MW-1:0]         cap_ext;
    logic [MW-1:0]         take_m;
    logic [PW-1:0]         wr_pos;
    logic [CW-1:0]         wr_cnt;
    efd_wr_ctl_t           wr_ctl_c;
    efd_wr_ctl_t           wr_ctl;
    logic [STATUS_W-1:0]   status_c;
    logic [FLOOR_W-1:0]    chosen_c;
    logic [TAKEN_W-1:0]    taken_c;

    logic [CW-1:0]         cnt_a;
    logic [CW-1:0]         cnt_b;
    logic                  busy_a;
    logic                  busy_b;

    // Handshake
    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_free      = !out_valid_reg || result.ready;

    // Served floors: floors_in_use capped at NUM_FLOORS
    assign n_srv     = (PW'(fiu_reg) > NF_P) ? NF_P : PW'(fiu_reg);
    assign start_srv = start_reg < n_srv;

    // Read addresses: request floor while idle, next distance otherwise
    assign iss_d  = (state_reg == S_SCAN) ? d_reg + PW'(1) : PW'(1);
    assign addr_a = (state_reg == S_IDLE) ? PW'(request.floor) : start_reg + iss_d;
    assign addr_b = start_reg - iss_d;

    // Scan positions at the distance now being evaluated
    assign up_pos  = start_reg + d_reg;
    assign dn_pos  = start_reg - d_reg;
    assign up_srv  = up_pos < n_srv;
    assign dn_srv  = (d_reg <= start_reg) && (dn_pos < n_srv);
    assign up_free = (up_srv && !busy_a) ? cnt_a : '0;
    assign dn_free = (dn_srv && !busy_b) ? cnt_b : '0;

    // Pickup amount: min(count, capacity)
    assign cnt_ext = MW'(cnt_a);
    assign cap_ext = MW'(cap_reg);
    assign take_m  = (cnt_ext > cap_ext) ? cap_ext : cnt_ext;

    // Sequencer and shared compare step
    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        d_next     = d_reg;
        finish     = 1'b0;
        wr_ctl_c   = '0;
        wr_pos     = start_reg;
        wr_cnt     = cnt_a;
        status_c   = ST_NONE;
        chosen_c   = '0;
        taken_c    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    start_next = PW'(request.floor);
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                case (op_reg)
                    OP_ARRIVE:
                    begin
                        finish = 1'b1;
                        if (start_srv)
                        begin
                            if (({1'b0, cnt_a} + (CW+1)'(1)) < QD_L)
                            begin
                                wr_ctl_c.cnt_we = 1'b1;
                                wr_cnt          = cnt_a + CW'(1);
                                status_c        = ST_OK;
                            end
                            else
                            begin
                                status_c = ST_FULL;
                            end
                        end
                    end

                    OP_PICKUP:
                    begin
                        finish = 1'b1;
                        if (start_srv)
                        begin
                            wr_ctl_c.cnt_we   = 1'b1;
                            wr_ctl_c.busy_clr = 1'b1;
                            wr_cnt            = cnt_a - take_m[CW-1:0];
                            status_c          = ST_OK;
                            taken_c           = take_m[TAKEN_W-1:0];
                        end
                    end

                    OP_DISPATCH:
                    begin
                        if (start_srv && !busy_a && (cnt_a != '0))
                        begin
                            finish            = 1'b1;
                            wr_ctl_c.busy_set = 1'b1;
                            status_c          = ST_OK;
                            chosen_c          = start_reg[FLOOR_W-1:0];
                        end
                        else
                        begin
                            d_next     = PW'(1);
                            state_next = S_SCAN;
                        end
                    end

                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (!(up_srv || dn_srv))
                begin
                    finish = 1'b1;
                end
                else if (up_free > dn_free)
                begin
                    finish            = 1'b1;
                    wr_ctl_c.busy_set = 1'b1;
                    wr_pos            = up_pos;
                    status_c          = ST_OK;
                    chosen_c          = up_pos[FLOOR_W-1:0];
                end
                else if (dn_free > up_free)
                begin
                    finish            = 1'b1;
                    wr_ctl_c.busy_set = 1'b1;
                    wr_pos            = dn_pos;
                    status_c          = ST_OK;
                    chosen_c          = dn_pos[FLOOR_W-1:0];
                end
                else
                begin
                    d_next = d_reg + PW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = out_free ? S_IDLE : state_reg;
            d_next     = d_reg;
        end
    end

    assign commit = finish && out_free;
    assign stall  = finish && !out_free;

    // Store writes only on the committing step
    assign wr_ctl.cnt_we   = wr_ctl_c.cnt_we   && commit;
    assign wr_ctl.busy_set = wr_ctl_c.busy_set && commit;
    assign wr_ctl.busy_clr = wr_ctl_c.busy_clr && commit;

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    efd_store #(
        .NUM_FLOORS (NUM_FLOORS),
        .CNT_W      (CW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (!stall),
        .rd_a_idx  (addr_a[FW-1:0]),
        .rd_b_idx  (addr_b[FW-1:0]),
        .rd_a_cnt  (cnt_a),
        .rd_a_busy (busy_a),
        .rd_b_cnt  (cnt_b),
        .rd_b_busy (busy_b),
        .wr_ctl    (wr_ctl),
        .wr_idx    (wr_pos[FW-1:0]),
        .wr_cnt    (wr_cnt)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fiu_reg       <= FIU_RESET;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_FLOORS_IN_USE: fiu_reg <= cfg_data[FIU_W-1:0];
                    REG_CAR_CAPACITY:  cap_reg <= cfg_data[CAP_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        d_reg     <= d_next;
        if (accept)
        begin
            op_reg <= request.op;
        end
        if (commit)
        begin
            status_reg <= status_c;
            chosen_reg <= chosen_c;
            taken_reg  <= taken_c;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.chosen_floor = chosen_reg;
    assign result.people_taken = taken_reg;

`ifndef SYNTHESIS
    // An accepted item always goes to the first evaluation step
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EVAL))
        else $error("accepted item did not enter evaluation");

    // The scan never evaluates distance zero
    a_scan_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (d_reg != '0))
        else $error("scan at distance zero");

    // A full-queue result carries no floor and no people
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == ST_FULL)) |->
            ((result.chosen_floor == '0) && (result.people_taken == '0)))
        else $error("full status with nonzero fields");

    // Pickup never takes more than one car's capacity
    a_taken_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.people_taken <= cap_reg))
        else $error("people taken above car capacity");

    // A held result is not overwritten while the receiver stalls
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(status_reg) && $stable(chosen_reg))
        else $error("pending result changed under stall");
`endif

endmodule
